// ----- hw/rtl/token_embedding_with_sinusoidal_position_assert.svh -----
// assertion macros used by tesp_back
`ifndef TOKEN_EMBEDDING_WITH_SINUSOIDAL_POSITION_ASSERT_SVH
`define TOKEN_EMBEDDING_WITH_SINUSOIDAL_POSITION_ASSERT_SVH
`ifndef SYNTHESIS
`define TESP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define TESP_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define TESP_ASSERT(name, prop, msg)
`define TESP_ASSERT_NEVER(name, cond, msg)
`endif
`endif

// ----- hw/rtl/tesp_pkg.sv -----
`default_nettype none
package tesp_pkg;

  localparam int unsigned VOCAB_MAX = 4096;
  localparam int unsigned DIM_MAX   = 64;
  localparam int unsigned POS_MAX   = 4096;

  localparam int unsigned ROW_W     = $clog2(VOCAB_MAX);
  localparam int unsigned DSEL_W    = $clog2(DIM_MAX);
  localparam int unsigned ADDR_W    = ROW_W + DSEL_W;
  localparam int unsigned MEM_DEPTH = VOCAB_MAX * DIM_MAX;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned STEP_W       = $clog2(CORDIC_STEPS);
  localparam int unsigned XY_W         = 34;
  localparam int unsigned Z_W          = 32;
  localparam logic signed [XY_W-1:0] CORDIC_X0 = 34'sd652032874;
  localparam logic [29:0] INV_TWO_PI = 30'd683565275;
  localparam logic [32:0] FREQ_ONE   = 33'h1_0000_0000;

  typedef enum logic [1:0] {
    REG_EMBED_DIM  = 2'd0,
    REG_VOCAB_SIZE = 2'd1,
    REG_PE_ENABLE  = 2'd2,
    REG_FREQ_RATIO = 2'd3
  } reg_idx_e;

  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_EMBED = 1'b1
  } req_type_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ANGLE,
    ST_PHASE_MUL,
    ST_PHASE,
    ST_CORDIC,
    ST_FETCH,
    ST_EMIT,
    ST_FREQ_MUL,
    ST_FREQ_SUM
  } back_state_e;

  typedef struct packed {
    req_type_e          req_type;
    logic signed [31:0] tok_id;
    logic [11:0]        position;
    logic [5:0]         dim_index;
    logic signed [15:0] table_value;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] out_value;
    logic [5:0]         out_dim;
    logic               token_invalid;
    logic               last;
  } out_item_t;

  typedef struct packed {
    req_type_e         kind;
    logic              wr_ok;
    logic              invalid;
    logic [ROW_W-1:0]  row;
    logic [11:0]       pos;
    logic [DSEL_W-1:0] dim;
    logic [15:0]       value;
  } cmd_t;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic [1:0]             quad;
  } cordic_res_t;

  // arctangent of 2^-i in Q0.32 turns
  function automatic logic [29:0] atan_turn(logic [STEP_W-1:0] i);
    logic [29:0] r;
    case (i)
      4'd0:  r = 30'd536870912;
      4'd1:  r = 30'd316933406;
      4'd2:  r = 30'd167458907;
      4'd3:  r = 30'd85004756;
      4'd4:  r = 30'd42667331;
      4'd5:  r = 30'd21354465;
      4'd6:  r = 30'd10679838;
      4'd7:  r = 30'd5340245;
      4'd8:  r = 30'd2670163;
      4'd9:  r = 30'd1335087;
      4'd10: r = 30'd667544;
      4'd11: r = 30'd333772;
      4'd12: r = 30'd166886;
      4'd13: r = 30'd83443;
      4'd14: r = 30'd41722;
      4'd15: r = 30'd20861;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/tesp_ram.sv -----
`default_nettype none
module tesp_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ----- hw/rtl/tesp_front.sv -----
`default_nettype none
module tesp_front import tesp_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire in_item_t    in_i,
  input  wire logic [12:0] vocab_size_i,
  output logic             cmd_valid_o,
  input  wire logic        cmd_ready_i,
  output cmd_t             cmd_o
);

  cmd_t              cmd_new;
  cmd_t              fifo_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              push, pop;
  logic [31:0]       id;

  // classify
  always_comb begin
    id = in_i.tok_id;
    cmd_new.kind    = in_i.req_type;
    cmd_new.wr_ok   = (id < 32'(VOCAB_MAX)) && ({1'b0, in_i.dim_index} < 7'(DIM_MAX));
    cmd_new.invalid = (id >= {19'b0, vocab_size_i}) || (id >= 32'(VOCAB_MAX));
    cmd_new.row     = id[ROW_W-1:0];
    cmd_new.pos     = (32'(in_i.position) >= 32'(POS_MAX)) ? 12'(POS_MAX - 1)
                                                            : in_i.position;
    cmd_new.dim     = in_i.dim_index[DSEL_W-1:0];
    cmd_new.value   = in_i.table_value;
  end

  assign in_ready_o  = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = fifo_q[rptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wptr_d = push ? QPTR_W'(wptr_q + 1'b1) : wptr_q;
    rptr_d = pop ? QPTR_W'(rptr_q + 1'b1) : rptr_q;
    cnt_d  = cnt_q;
    if (push && !pop) begin
      cnt_d = QCNT_W'(cnt_q + 1'b1);
    end else if (pop && !push) begin
      cnt_d = QCNT_W'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wptr_q] <= cmd_new;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/tesp_cordic.sv -----
`default_nettype none
module tesp_cordic import tesp_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] phase_i,
  output logic             busy_o,
  output logic             done_o,
  output cordic_res_t      res_o
);

  logic                   busy_q, busy_d, done_q, done_d;
  logic [STEP_W-1:0]      i_q, i_d;
  logic signed [XY_W-1:0] x_q, x_d, y_q, y_d, xs, ys;
  logic signed [Z_W-1:0]  z_q, z_d, at;
  logic [1:0]             quad_q, quad_d;
  logic [31:0]            p;

  always_comb begin
    p      = phase_i + 32'h2000_0000;
    xs     = x_q >>> i_q;
    ys     = y_q >>> i_q;
    at     = $signed({2'b00, atan_turn(i_q)});
    busy_d = busy_q;
    done_d = 1'b0;
    i_d    = i_q;
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    quad_d = quad_q;
    if (start_i) begin
      busy_d = 1'b1;
      i_d    = '0;
      x_d    = CORDIC_X0;
      y_d    = '0;
      z_d    = $signed({2'b00, p[29:0]}) - 32'sd536870912;
      quad_d = p[31:30];
    end else if (busy_q) begin
      if (z_q >= 0) begin
        x_d = x_q - ys;
        y_d = y_q + xs;
        z_d = z_q - at;
      end else begin
        x_d = x_q + ys;
        y_d = y_q - xs;
        z_d = z_q + at;
      end
      i_d = STEP_W'(i_q + 1'b1);
      if (i_q == STEP_W'(CORDIC_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q    <= i_d;
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    quad_q <= quad_d;
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign res_o.x    = x_q;
  assign res_o.y    = y_q;
  assign res_o.quad = quad_q;

endmodule
`default_nettype wire

// ----- hw/rtl/tesp_back.sv -----
`default_nettype none
`include "token_embedding_with_sinusoidal_position_assert.svh"
module tesp_back import tesp_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cmd_valid_i,
  output logic             cmd_ready_o,
  input  wire cmd_t        cmd_i,
  input  wire logic [6:0]  embed_dim_i,
  input  wire logic        pe_enable_i,
  input  wire logic [31:0] freq_ratio_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output out_item_t        out_o
);

  back_state_e       state_q, state_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [11:0]       pos_q, pos_d;
  logic              inv_q, inv_d;
  logic [6:0]        nd_q, nd_d, d_q, d_d, nd_new;
  logic [32:0]       freq_q, freq_d;
  logic [44:0]       ang_q, ang_d;
  logic [42:0]       pi_q, pi_d;
  logic [61:0]       pf_q, pf_d;
  logic [48:0]       fh_q, fh_d;
  logic [47:0]       fl_q, fl_d;
  logic signed [15:0] sin_q, sin_d, cos_q, cos_d;
  logic              out_valid_q, out_valid_d, out_load;
  out_item_t         out_q, out_d;

  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [15:0]       ram_rdata;

  logic              cordic_start, cordic_busy, cordic_done;
  logic [31:0]       phase;
  cordic_res_t       cres;

  logic signed [35:0] xe, ye, cv, sv, cr, sr;
  logic signed [15:0] word, term;
  logic signed [17:0] sum;
  logic [64:0]        fsum;

  tesp_ram #(
    .WIDTH(16),
    .DEPTH(MEM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (cmd_i.value),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  tesp_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cordic_start),
    .phase_i (phase),
    .busy_o  (cordic_busy),
    .done_o  (cordic_done),
    .res_o   (cres)
  );

  // quadrant fold and rounding to q3.12
  always_comb begin
    xe = {{2{cres.x[XY_W-1]}}, cres.x};
    ye = {{2{cres.y[XY_W-1]}}, cres.y};
    case (cres.quad)
      2'd0:    begin cv = xe;  sv = ye;  end
      2'd1:    begin cv = -ye; sv = xe;  end
      2'd2:    begin cv = -xe; sv = -ye; end
      default: begin cv = ye;  sv = -xe; end
    endcase
    cr = (cv + 36'sd131072) >>> 18;
    sr = (sv + 36'sd131072) >>> 18;
  end

  always_comb begin
    word = inv_q ? 16'sd0 : $signed(ram_rdata);
    term = pe_enable_i ? (d_q[0] ? cos_q : sin_q) : 16'sd0;
    sum  = {{2{word[15]}}, word} + {{2{term[15]}}, term};
    out_d.out_dim       = 6'(d_q);
    out_d.token_invalid = inv_q;
    out_d.last          = (7'(d_q + 1'b1) == nd_q);
    if (sum > 18'sd32767) begin
      out_d.out_value = 16'sh7fff;
    end else if (sum < -18'sd32768) begin
      out_d.out_value = 16'sh8000;
    end else begin
      out_d.out_value = sum[15:0];
    end
  end

  assign nd_new    = (embed_dim_i > 7'(DIM_MAX)) ? 7'(DIM_MAX) : embed_dim_i;
  assign phase     = 32'(pi_q + 43'(pf_q[61:32]));
  assign fsum      = (65'(fh_q) << 16) + 65'(fl_q);
  assign ram_waddr = {cmd_i.row, cmd_i.dim};
  assign ram_raddr = {row_q, d_q[DSEL_W-1:0]};
  assign cmd_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d      = state_q;
    row_d        = row_q;
    pos_d        = pos_q;
    inv_d        = inv_q;
    nd_d         = nd_q;
    d_d          = d_q;
    freq_d       = freq_q;
    ang_d        = ang_q;
    pi_d         = pi_q;
    pf_d         = pf_q;
    fh_d         = fh_q;
    fl_d         = fl_q;
    sin_d        = sin_q;
    cos_d        = cos_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    cordic_start = 1'b0;
    out_load     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          if (cmd_i.kind == REQ_WRITE) begin
            ram_we = cmd_i.wr_ok;
          end else begin
            row_d  = cmd_i.row;
            pos_d  = cmd_i.pos;
            inv_d  = cmd_i.invalid;
            nd_d   = nd_new;
            d_d    = '0;
            freq_d = FREQ_ONE;
            if (nd_new != '0) begin
              state_d = pe_enable_i ? ST_ANGLE : ST_FETCH;
            end
          end
        end
      end
      ST_ANGLE: begin
        ang_d   = 45'(pos_q) * 45'(freq_q);
        state_d = ST_PHASE_MUL;
      end
      ST_PHASE_MUL: begin
        pi_d    = 43'(ang_q[44:32]) * 43'(INV_TWO_PI);
        pf_d    = 62'(ang_q[31:0]) * 62'(INV_TWO_PI);
        state_d = ST_PHASE;
      end
      ST_PHASE: begin
        cordic_start = 1'b1;
        state_d      = ST_CORDIC;
      end
      ST_CORDIC: begin
        if (cordic_done) begin
          sin_d   = sr[15:0];
          cos_d   = cr[15:0];
          state_d = ST_FETCH;
        end
      end
      ST_FETCH: begin
        ram_re  = 1'b1;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          if (out_d.last) begin
            state_d = ST_IDLE;
          end else begin
            d_d     = 7'(d_q + 1'b1);
            state_d = (pe_enable_i && d_q[0]) ? ST_FREQ_MUL : ST_FETCH;
          end
        end
      end
      ST_FREQ_MUL: begin
        fh_d    = 49'(freq_q[32:16]) * 49'(freq_ratio_i);
        fl_d    = 48'(freq_q[15:0]) * 48'(freq_ratio_i);
        state_d = ST_FREQ_SUM;
      end
      ST_FREQ_SUM: begin
        freq_d  = 33'(fsum >> 32);
        state_d = ST_ANGLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      d_q         <= '0;
      nd_q        <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      d_q         <= d_d;
      nd_q        <= nd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q  <= row_d;
    pos_q  <= pos_d;
    inv_q  <= inv_d;
    freq_q <= freq_d;
    ang_q  <= ang_d;
    pi_q   <= pi_d;
    pf_q   <= pf_d;
    fh_q   <= fh_d;
    fl_q   <= fl_d;
    sin_q  <= sin_d;
    cos_q  <= cos_d;
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  `TESP_ASSERT(dim_below_count, (state_q != ST_IDLE) |-> (d_q < nd_q), "dimension past count")
  `TESP_ASSERT(cordic_start_free, cordic_start |-> !cordic_busy, "cordic restarted while busy")
  `TESP_ASSERT(last_ends_token, (out_load && out_d.last) |=> (state_q == ST_IDLE), "no idle after last")
  `TESP_ASSERT_NEVER(load_outside_emit, out_load && (state_q != ST_EMIT), "result loaded off emit")

endmodule
`default_nettype wire

// ----- hw/rtl/token_embedding_with_sinusoidal_position.sv -----
// channel   | handshake                  | payload
// ----------+----------------------------+-------------------------------
// in        | in_valid_i / in_ready_o    | in_i (in_item_t)
// out       | out_valid_o / out_ready_i  | out_o (out_item_t)
// config    | psel penable pwrite pready | paddr pwdata prdata
//
// the sequencer takes a table write while idle; an embed fetches and emits
// each dimension in turn, and with the position term each dimension pair
// also waits on the 16-step iterative cordic and the split frequency
// multiply. a 2-entry queue lets input be taken while the
// sequencer works; the output register holds a result under stall.
// reset clears control state only; the table is undefined until written
`default_nettype none
module token_embedding_with_sinusoidal_position import tesp_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire in_item_t    in_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output out_item_t        out_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [6:0]  embed_dim_q;
  logic [12:0] vocab_size_q;
  logic        pe_enable_q;
  logic [31:0] freq_ratio_q;
  logic        cfg_we;
  reg_idx_e    cfg_idx;
  logic        cmd_valid, cmd_ready;
  cmd_t        cmd;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      embed_dim_q  <= 7'd64;
      vocab_size_q <= 13'd4096;
      pe_enable_q  <= 1'b0;
      freq_ratio_q <= 32'd3220764000;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_EMBED_DIM:  embed_dim_q  <= pwdata[6:0];
        REG_VOCAB_SIZE: vocab_size_q <= pwdata[12:0];
        REG_PE_ENABLE:  pe_enable_q  <= pwdata[0];
        REG_FREQ_RATIO: freq_ratio_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_EMBED_DIM:  prdata = {25'b0, embed_dim_q};
      REG_VOCAB_SIZE: prdata = {19'b0, vocab_size_q};
      REG_PE_ENABLE:  prdata = {31'b0, pe_enable_q};
      REG_FREQ_RATIO: prdata = freq_ratio_q;
      default:        prdata = '0;
    endcase
  end

  tesp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_i         (in_i),
    .vocab_size_i (vocab_size_q),
    .cmd_valid_o  (cmd_valid),
    .cmd_ready_i  (cmd_ready),
    .cmd_o        (cmd)
  );

  tesp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_valid),
    .cmd_ready_o  (cmd_ready),
    .cmd_i        (cmd),
    .embed_dim_i  (embed_dim_q),
    .pe_enable_i  (pe_enable_q),
    .freq_ratio_i (freq_ratio_q),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_o        (out_o)
  );

endmodule
`default_nettype wire
